### src/sfs_pkg.sv
package sfs_pkg;

  // Register map, one 32-bit word per register.
  typedef enum logic [2:0] {
    RegSpringRate   = 3'd0,
    RegPreload      = 3'd1,
    RegLeverRatio   = 3'd2,
    RegTravelMax    = 3'd3,
    RegBumpSlow     = 3'd4,
    RegBumpFast     = 3'd5,
    RegReboundSlow  = 3'd6,
    RegReboundFast  = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    LimitNone   = 2'd0,
    LimitPacker = 2'd1,
    LimitMax    = 2'd2
  } limit_e;

  // Travel below this is raised to it, Q8.16 metres.
  localparam logic signed [23:0] PackerGap = 24'sd0;

  // Damper speed clamp (10 m/s) and knee (0.5 m/s), Q8.16.
  localparam logic signed [23:0] SpeedLimit = 24'sd655360;
  localparam logic [19:0]        KneeSpeed  = 20'd32768;

  localparam logic [23:0] SpringRateRst = 24'd175000;
  localparam logic [31:0] PreloadRst    = 32'd0;
  localparam logic [15:0] LeverRatioRst = 16'd4096;
  localparam logic [22:0] TravelMaxRst  = 23'd32768;

endpackage

### src/suspension_force_step_unit.sv
// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+---------------------------------------
// request   | in        | start, busy            | travel_raw_i, damper_speed_i
// result    | out       | done_o (one-cycle)     | total_force_o, travel_clamped_o,
//           |           |                        | limit_status_o
// config    | in        | psel, penable, pwrite  | paddr, pwdata, prdata (pready tied)
//
// A request is taken in every cycle; busy is never raised.
// Each result passes in order through the seven-stage
// pipeline (travel scaling, damper multiply, split spring multiply, preload
// subtract, lever multiply, saturation).
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// The receiver cannot stall, so the pipeline never holds.
module suspension_force_step_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] travel_raw_i,
  input  logic signed [23:0] damper_speed_i,
  output logic               done_o,
  output logic signed [31:0] total_force_o,
  output logic signed [23:0] travel_clamped_o,
  output logic [1:0]         limit_status_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import sfs_pkg::*;

  // Configuration registers.
  logic [23:0] spring_rate_q;
  logic [31:0] preload_q;
  logic [15:0] lever_ratio_q;
  logic [22:0] travel_max_q;
  logic [19:0] bump_slow_q, bump_fast_q, rebound_slow_q, rebound_fast_q;

  cfg_reg_e cfg_sel;
  logic     cfg_we;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign cfg_sel = cfg_reg_e'(paddr[4:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spring_rate_q  <= SpringRateRst;
      preload_q      <= PreloadRst;
      lever_ratio_q  <= LeverRatioRst;
      travel_max_q   <= TravelMaxRst;
      bump_slow_q    <= '0;
      bump_fast_q    <= '0;
      rebound_slow_q <= '0;
      rebound_fast_q <= '0;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        RegSpringRate:  spring_rate_q  <= pwdata[23:0];
        RegPreload:     preload_q      <= pwdata;
        RegLeverRatio:  lever_ratio_q  <= pwdata[15:0];
        RegTravelMax:   travel_max_q   <= pwdata[22:0];
        RegBumpSlow:    bump_slow_q    <= pwdata[19:0];
        RegBumpFast:    bump_fast_q    <= pwdata[19:0];
        RegReboundSlow: rebound_slow_q <= pwdata[19:0];
        RegReboundFast: rebound_fast_q <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      RegSpringRate:  prdata = {8'd0, spring_rate_q};
      RegPreload:     prdata = preload_q;
      RegLeverRatio:  prdata = {16'd0, lever_ratio_q};
      RegTravelMax:   prdata = {9'd0, travel_max_q};
      RegBumpSlow:    prdata = {12'd0, bump_slow_q};
      RegBumpFast:    prdata = {12'd0, bump_fast_q};
      RegReboundSlow: prdata = {12'd0, rebound_slow_q};
      RegReboundFast: prdata = {12'd0, rebound_fast_q};
      default:        prdata = '0;
    endcase
  end

  // Valid bits of the seven stages.
  logic [6:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[5:0], start && !busy};
    end
  end

  assign done_o = vld_q[6];

  // Stage 1: packer limit, lever product of the travel, damper operand selection.
  logic              s1_packer_d;
  logic [22:0]       s1_tpack;
  logic [38:0]       s1_tprod_d;
  logic signed [23:0] s1_vclamp;
  logic              s1_reb_d;
  logic [19:0]       s1_av, s1_slow, s1_fast;
  logic              s1_below_knee;
  logic [19:0]       s1_mula_d, s1_mulb_d, s1_add_d;

  always_comb begin
    s1_packer_d = travel_raw_i < PackerGap;
    // Not below the gap means not negative, so the sign bit is zero.
    s1_tpack    = s1_packer_d ? PackerGap[22:0] : travel_raw_i[22:0];
    s1_tprod_d  = 39'(s1_tpack) * 39'(lever_ratio_q);

    if (damper_speed_i > SpeedLimit) begin
      s1_vclamp = SpeedLimit;
    end else if (damper_speed_i < -SpeedLimit) begin
      s1_vclamp = -SpeedLimit;
    end else begin
      s1_vclamp = damper_speed_i;
    end
    s1_reb_d      = s1_vclamp[23];
    s1_av         = s1_reb_d ? 20'(-s1_vclamp) : 20'(s1_vclamp);
    s1_slow       = s1_reb_d ? rebound_slow_q : bump_slow_q;
    s1_fast       = s1_reb_d ? rebound_fast_q : bump_fast_q;
    s1_below_knee = s1_av < KneeSpeed;
    // Above the knee the force is fast*(|v|-knee) plus slow*knee.
    s1_mula_d     = s1_below_knee ? s1_slow : s1_fast;
    s1_mulb_d     = s1_below_knee ? s1_av : s1_av - KneeSpeed;
    s1_add_d      = s1_below_knee ? 20'd0 : s1_slow;
  end

  logic        s1_packer_q, s1_reb_q;
  logic [38:0] s1_tprod_q;
  logic [19:0] s1_mula_q, s1_mulb_q, s1_add_q;

  // Stage 2: scale and cap travel, damper multiply.
  logic [26:0] s2_tscaled;
  logic        s2_over;
  logic [22:0] s2_t_d;
  limit_e      s2_status_d;
  logic [39:0] s2_dprod_d;

  always_comb begin
    s2_tscaled  = s1_tprod_q[38:12];
    s2_over     = s2_tscaled > {4'd0, travel_max_q};
    s2_t_d      = s2_over ? travel_max_q : s2_tscaled[22:0];
    if (s2_over) begin
      s2_status_d = LimitMax;
    end else if (s1_packer_q) begin
      s2_status_d = LimitPacker;
    end else begin
      s2_status_d = LimitNone;
    end
    s2_dprod_d  = 40'(s1_mula_q) * 40'(s1_mulb_q);
  end

  logic [22:0] s2_t_q;
  limit_e      s2_status_q;
  logic [39:0] s2_dprod_q;
  logic [19:0] s2_add_q;
  logic        s2_reb_q;

  // Stage 3: spring rate times travel in two partial products, damper magnitude.
  logic [35:0] s3_pplo_d;
  logic [34:0] s3_pphi_d;
  logic [40:0] s3_mag;
  logic [32:0] s3_dmag_d;

  always_comb begin
    s3_pplo_d = 36'(spring_rate_q) * 36'(s2_t_q[11:0]);
    s3_pphi_d = 35'(spring_rate_q) * 35'(s2_t_q[22:12]);
    s3_mag    = 41'(s2_dprod_q) + (41'(s2_add_q) << 15);
    s3_dmag_d = s3_mag[40:8];
  end

  logic [22:0] s3_t_q;
  limit_e      s3_status_q;
  logic [35:0] s3_pplo_q;
  logic [34:0] s3_pphi_q;
  logic [32:0] s3_dmag_q;
  logic        s3_reb_q;

  // Stage 4: combine the partial products, sign the damper force.
  logic [46:0] s4_sprod;
  logic [38:0] s4_sshift_d;
  logic [33:0] s4_damp_d;

  always_comb begin
    s4_sprod    = (47'(s3_pphi_q) << 12) + 47'(s3_pplo_q);
    s4_sshift_d = s4_sprod[46:8];
    // Magnitude is floored first, so the signed force rounds toward zero.
    s4_damp_d   = s3_reb_q ? 34'd0 - {1'b0, s3_dmag_q} : {1'b0, s3_dmag_q};
  end

  logic [22:0] s4_t_q;
  limit_e      s4_status_q;
  logic [38:0] s4_sshift_q;
  logic [33:0] s4_damp_q;

  // Stage 5: preload minus spring term, floored at zero.
  logic [40:0] s5_spring_full;
  logic [30:0] s5_spring_d;

  always_comb begin
    s5_spring_full = {{9{preload_q[31]}}, preload_q} - {2'b00, s4_sshift_q};
    s5_spring_d    = s5_spring_full[40] ? 31'd0 : s5_spring_full[30:0];
  end

  logic [22:0] s5_t_q;
  limit_e      s5_status_q;
  logic [30:0] s5_spring_q;
  logic [33:0] s5_damp_q;

  // Stage 6: total times lever ratio.
  logic [34:0]        s6_sum;
  logic signed [51:0] s6_prod_d;

  always_comb begin
    s6_sum    = {4'd0, s5_spring_q} + {s5_damp_q[33], s5_damp_q};
    s6_prod_d = $signed(s6_sum) * $signed({1'b0, lever_ratio_q});
  end

  logic [22:0]        s6_t_q;
  limit_e             s6_status_q;
  logic signed [51:0] s6_prod_q;

  // Stage 7: floor shift and saturate to 32 bits.
  logic [39:0] s7_sh;
  logic        s7_sat_hi, s7_sat_lo;
  logic [31:0] s7_force_d;

  always_comb begin
    s7_sh     = s6_prod_q[51:12];
    s7_sat_hi = !s7_sh[39] && (s7_sh[38:31] != 8'h00);
    s7_sat_lo = s7_sh[39] && (s7_sh[38:31] != 8'hFF);
    if (s7_sat_hi) begin
      s7_force_d = 32'h7FFF_FFFF;
    end else if (s7_sat_lo) begin
      s7_force_d = 32'h8000_0000;
    end else begin
      s7_force_d = s7_sh[31:0];
    end
  end

  logic [31:0] s7_force_q;
  logic [22:0] s7_t_q;
  limit_e      s7_status_q;

  always_ff @(posedge clk_i) begin
    s1_packer_q <= s1_packer_d;
    s1_tprod_q  <= s1_tprod_d;
    s1_reb_q    <= s1_reb_d;
    s1_mula_q   <= s1_mula_d;
    s1_mulb_q   <= s1_mulb_d;
    s1_add_q    <= s1_add_d;

    s2_t_q      <= s2_t_d;
    s2_status_q <= s2_status_d;
    s2_dprod_q  <= s2_dprod_d;
    s2_add_q    <= s1_add_q;
    s2_reb_q    <= s1_reb_q;

    s3_t_q      <= s2_t_q;
    s3_status_q <= s2_status_q;
    s3_pplo_q   <= s3_pplo_d;
    s3_pphi_q   <= s3_pphi_d;
    s3_dmag_q   <= s3_dmag_d;
    s3_reb_q    <= s2_reb_q;

    s4_t_q      <= s3_t_q;
    s4_status_q <= s3_status_q;
    s4_sshift_q <= s4_sshift_d;
    s4_damp_q   <= s4_damp_d;

    s5_t_q      <= s4_t_q;
    s5_status_q <= s4_status_q;
    s5_spring_q <= s5_spring_d;
    s5_damp_q   <= s4_damp_q;

    s6_t_q      <= s5_t_q;
    s6_status_q <= s5_status_q;
    s6_prod_q   <= s6_prod_d;

    s7_force_q  <= s7_force_d;
    s7_t_q      <= s6_t_q;
    s7_status_q <= s6_status_q;
  end

  assign total_force_o    = s7_force_q;
  assign travel_clamped_o = {1'b0, s7_t_q};
  assign limit_status_o   = s7_status_q;

endmodule
